// ===== sv/fpa_pkg.sv =====
// shared types and constants for the q24.8 fixed-point alu
package fpa_pkg;

  localparam int unsigned DefaultFracBits = 8;
  localparam int unsigned WordW = 32;
  localparam int unsigned OpW = 4;

  typedef enum logic [OpW-1:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_MUL   = 4'd2,
    OP_DIV   = 4'd3,
    OP_MIN   = 4'd4,
    OP_MAX   = 4'd5,
    OP_INC   = 4'd6,
    OP_DEC   = 4'd7,
    OP_ITOF  = 4'd8,
    OP_FTOI  = 4'd9,
    OP_NONE1 = 4'd10,
    OP_NONE2 = 4'd11,
    OP_NONE3 = 4'd12,
    OP_NONE4 = 4'd13,
    OP_NONE5 = 4'd14,
    OP_NONE6 = 4'd15
  } op_e;

  // state carried along the divider chain, one slot per cell
  typedef struct packed {
    logic             vld;
    logic [OpW-1:0]   op;
    logic [WordW-1:0] res;   // result of the non-divide ops
    logic             gt;
    logic             lt;
    logic             eq;
    logic             dz;
    logic             neg;   // quotient sign
    logic [63:0]      rem;   // pending dividend bits, next one at bit DivW-1
    logic [WordW-1:0] prem;  // partial remainder, below the divisor whenever the divisor is nonzero
    logic [WordW-1:0] quo;   // quotient bits so far (wrapped)
    logic [WordW-1:0] dvs;   // divisor magnitude
  } slot_t;

endpackage

// ===== sv/fpa_cell.sv =====
// one restoring-division cell: retires one quotient bit per cycle while en_i is high
module fpa_cell import fpa_pkg::*; #(
  parameter int unsigned DivW = 40
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  slot_t slot_i,
  output slot_t slot_o
);

  slot_t slot_d, slot_q;
  logic [WordW:0] trial;
  logic [WordW:0] part;

  // bring down the next dividend bit and try to subtract the divisor
  always_comb begin
    slot_d = slot_i;
    part   = {slot_i.prem, slot_i.rem[DivW-1]};
    trial  = part - {1'b0, slot_i.dvs};
    slot_d.rem = {slot_i.rem[62:0], 1'b0};
    if (!trial[WordW]) begin
      slot_d.prem = trial[WordW-1:0];
    end else begin
      slot_d.prem = part[WordW-1:0];
    end
    slot_d.quo = {slot_i.quo[WordW-2:0], ~trial[WordW]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (en_i) begin
      slot_q <= slot_d;
    end
  end

  assign slot_o = slot_q;

endmodule

// ===== sv/fixed_point_alu_q24_8_top.sv =====
// q24.8 fixed-point alu: operand stage, divider cell chain, output register
// throughput: one transaction per cycle while the output is not stalled; the divider chain has one cell per
//   dividend bit (32 + FRACTION_BITS) and all items run through it in order
// the whole chain advances only when the output register can take data
// reset clears the operand and cell registers and the output valid flag; no state survives between items
module fixed_point_alu_q24_8_top import fpa_pkg::*; #(
  parameter int unsigned FRACTION_BITS = DefaultFracBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [3:0] opcode, [35:4] operand_a, [67:36] operand_b, [71:68] zero
  input  logic [71:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [31:0] result, [32] a_greater, [33] a_less, [34] a_equal,
  // [35] divide_by_zero, [39:36] zero
  output logic [39:0] m_axis_tdata_o
);

  localparam int unsigned DivW = WordW + FRACTION_BITS;

  logic [OpW-1:0]          op;
  logic signed [WordW-1:0] a, b;
  logic                    adv;

  assign op = s_axis_tdata_i[3:0];
  assign a  = s_axis_tdata_i[35:4];
  assign b  = s_axis_tdata_i[67:36];

  // stage 0: multiply product register plus operands
  slot_t s0_q;
  logic signed [63:0] prod_q;
  logic [WordW-1:0] res0;
  logic [WordW-1:0] ma, mb;

  assign ma = a[WordW-1] ? WordW'(-a) : a;
  assign mb = b[WordW-1] ? WordW'(-b) : b;

  always_comb begin
    case (op_e'(op))
      OP_ADD:  res0 = a + b;
      OP_SUB:  res0 = a - b;
      OP_MIN:  res0 = (a < b) ? a : b;
      OP_MAX:  res0 = (a > b) ? a : b;
      OP_INC:  res0 = a + 32'sd1;
      OP_DEC:  res0 = a - 32'sd1;
      OP_ITOF: res0 = a <<< FRACTION_BITS;
      OP_FTOI: res0 = a >>> FRACTION_BITS;
      default: res0 = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_q <= '0;
    end else if (adv) begin
      s0_q.vld  <= s_axis_tvalid_i;
      s0_q.op   <= op;
      s0_q.res  <= res0;
      s0_q.gt   <= a > b;
      s0_q.lt   <= a < b;
      s0_q.eq   <= a == b;
      s0_q.dz   <= (op_e'(op) == OP_DIV) && (b == '0);
      s0_q.neg  <= a[WordW-1] ^ b[WordW-1];
      s0_q.rem  <= {{(64-DivW){1'b0}}, ma, {FRACTION_BITS{1'b0}}};
      s0_q.prem <= '0;
      s0_q.quo  <= '0;
      s0_q.dvs  <= mb;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q <= 64'(a) * 64'(b);
    end
  end

  // fold the multiply result in before the chain
  slot_t chain [DivW+1];
  logic [63:0] psh;
  assign psh = prod_q >>> FRACTION_BITS;
  always_comb begin
    chain[0] = s0_q;
    if (op_e'(s0_q.op) == OP_MUL) chain[0].res = psh[WordW-1:0];
  end

  for (genvar g = 0; g < DivW; g++) begin : g_cell
    fpa_cell #(.DivW(DivW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .slot_i (chain[g]),
      .slot_o (chain[g+1])
    );
  end

  slot_t last;
  logic [WordW-1:0] res_f;
  assign last = chain[DivW];

  always_comb begin
    res_f = last.res;
    if (op_e'(last.op) == OP_DIV) begin
      if (last.dz) res_f = '0;
      else res_f = last.neg ? -last.quo : last.quo;
    end
  end

  logic        out_vld_q;
  logic [35:0] out_q;

  assign adv = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= last.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_q <= {last.dz, last.eq, last.lt, last.gt, res_f};
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {4'b0, out_q};

`ifndef ASSERT_OFF
  a_flags_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> $onehot(out_q[34:32]))
    else $error("comparison flags not one-hot");
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q[35]) |-> (out_q[31:0] == '0))
    else $error("divide by zero with nonzero result");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> $stable(m_axis_tdata_o))
    else $error("stalled result changed");
`endif

endmodule

// ===== tb/sv/tb_fixed_point_alu_q24_8_top.sv =====
// testbench for the q24.8 fixed-point alu: random and directed operations, scoreboard check
`timescale 1ns / 1ps

module tb_fixed_point_alu_q24_8_top;
  import fpa_pkg::*;

  localparam int unsigned FracBits = DefaultFracBits;
  localparam int unsigned NumRandom = 2000;
  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned Latency = FracBits + 33;

  typedef struct {
    logic [31:0] result;
    logic        gt;
    logic        lt;
    logic        eq;
    logic        dz;
  } alu_out_t;

  class alu_scoreboard;
    alu_out_t pending[$];
    int errors;

    function alu_out_t compute(op_e op, logic signed [31:0] a, logic signed [31:0] b);
      alu_out_t r;
      logic signed [63:0] prod;
      logic signed [63:0] dvd;
      logic signed [63:0] quo;
      r.gt = a > b;
      r.lt = a < b;
      r.eq = a == b;
      r.dz = 1'b0;
      r.result = '0;
      case (op)
        OP_ADD: r.result = a + b;
        OP_SUB: r.result = a - b;
        OP_MUL: begin
          prod = 64'(a) * 64'(b);
          r.result = 32'(prod >>> FracBits);
        end
        OP_DIV: begin
          if (b == 0) begin
            r.dz = 1'b1;
          end else begin
            // signed division truncates toward zero
            dvd = 64'(a) <<< FracBits;
            quo = dvd / 64'(b);
            r.result = quo[31:0];
          end
        end
        OP_MIN: r.result = (a < b) ? a : b;
        OP_MAX: r.result = (a > b) ? a : b;
        OP_INC: r.result = a + 32'sd1;
        OP_DEC: r.result = a - 32'sd1;
        OP_ITOF: r.result = a <<< FracBits;
        OP_FTOI: r.result = a >>> FracBits;
        default: r.result = '0;
      endcase
      return r;
    endfunction

    function void note_operation(logic [71:0] d);
      pending.push_back(compute(op_e'(d[3:0]), d[35:4], d[67:36]));
    endfunction

    function void check_result(logic [39:0] d);
      alu_out_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %h", d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[31:0] !== e.result) begin
        $error("result: expected %h, actual %h", e.result, d[31:0]); errors++;
      end
      if (d[32] !== e.gt) begin
        $error("a_greater: expected %b, actual %b", e.gt, d[32]); errors++;
      end
      if (d[33] !== e.lt) begin
        $error("a_less: expected %b, actual %b", e.lt, d[33]); errors++;
      end
      if (d[34] !== e.eq) begin
        $error("a_equal: expected %b, actual %b", e.eq, d[34]); errors++;
      end
      if (d[35] !== e.dz) begin
        $error("divide_by_zero: expected %b, actual %b", e.dz, d[35]); errors++;
      end
      if (d[39:36] !== 4'd0) begin
        $error("tdata pad: expected 0, actual %h", d[39:36]); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [71:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;

  alu_scoreboard sb = new();
  int idle_cycles = 0;
  bit stim_done = 1'b0;

  always #5 clk_i = ~clk_i;

  fixed_point_alu_q24_8_top #(.FRACTION_BITS(FracBits)) uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o
  );

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return 32'(int'($urandom_range(0, 2047)) - 1024);
      4: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // one input transaction, then an optional gap
  task automatic send_op(logic [3:0] op, logic [31:0] a, logic [31:0] b);
    int g;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {4'd0, b, a, op};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_operation({4'd0, b, a, op});
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // sink side: random stalls with calm stretches
  initial begin
    int g;
    int calm;
    calm = 0;
    @(posedge rst_ni);
    forever begin
      if (calm > 0) begin
        calm--;
        m_axis_tready_i <= 1'b1;
        @(posedge clk_i);
      end else if ($urandom_range(0, 49) == 0) begin
        calm = $urandom_range(50, 300);
      end else begin
        g = gap_len();
        if (g > 0) begin
          m_axis_tready_i <= 1'b0;
          repeat (g) @(posedge clk_i);
        end
        m_axis_tready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o);
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("tb_fixed_point_alu_q24_8_top: done, errors");
      $finish;
    end
  end

  initial begin
    op_e op;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: every defined opcode, some unused ones, extremes, zero divisor, rounding of negatives
    send_op(OP_ADD, 32'h7fff_ffff, 32'h0000_0001);
    send_op(OP_SUB, 32'h8000_0000, 32'h0000_0001);
    send_op(OP_MUL, 32'h8000_0000, 32'h8000_0000);
    send_op(OP_MUL, 32'hffff_ff80, 32'h0000_0080);
    send_op(OP_DIV, 32'h0000_0300, 32'h0000_0000);
    send_op(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
    send_op(OP_DIV, 32'hffff_fd00, 32'h0000_0200);
    send_op(OP_DIV, 32'h7fff_ffff, 32'h0000_0001);
    send_op(OP_MIN, 32'h8000_0000, 32'h7fff_ffff);
    send_op(OP_MIN, 32'h0000_0005, 32'h0000_0005);
    send_op(OP_MAX, 32'h8000_0000, 32'h7fff_ffff);
    send_op(OP_MAX, 32'h0000_0007, 32'hffff_fff0);
    send_op(OP_INC, 32'h7fff_ffff, 32'h1234_5678);
    send_op(OP_DEC, 32'h8000_0000, 32'h8000_0000);
    send_op(OP_ITOF, 32'h00ff_ffff, 32'h0);
    send_op(OP_ITOF, 32'hff80_0001, 32'h0);
    send_op(OP_FTOI, 32'hffff_ff01, 32'h0);
    send_op(OP_FTOI, 32'h7fff_ffff, 32'h0);
    send_op(OP_NONE1, 32'h1, 32'h2);
    send_op(OP_NONE6, 32'hffff_ffff, 32'hffff_ffff);
    send_op(OP_NONE3, 32'h0, 32'h0);
    for (int i = 0; i < NumRandom; i++) begin
      op = op_e'($urandom_range(0, 9));
      if ($urandom_range(0, 19) == 0) op = op_e'($urandom_range(10, 15));
      send_op(op, pick_operand(), ($urandom_range(0, 9) == 0) ? 32'h0 : pick_operand());
    end
    s_axis_tvalid_i <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb_fixed_point_alu_q24_8_top: done, clean");
    end else begin
      $display("tb_fixed_point_alu_q24_8_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/fpa_pkg.sv
sv/fpa_cell.sv
sv/fixed_point_alu_q24_8_top.sv
tb/sv/tb_fixed_point_alu_q24_8_top.sv
